// ===== rtl/evo_pkg.sv =====
package evo_pkg;

    // Stripe geometry: DATA_DISKS data disks (assumed prime), DATA_DISKS-1 rows.
    localparam int DATA_DISKS = 5;
    localparam int ROWS       = DATA_DISKS - 1;
    localparam int NUM_CELLS  = 2 * ROWS;
    localparam int WORD_W     = 64;

    // Width that holds disk + row sums, DATA_DISKS itself and every cell index.
    localparam int DIAG_W = $clog2(DATA_DISKS + 8);
    // Drain counter width: indexes the 2*ROWS parity items of one stripe.
    localparam int CNT_W  = $clog2(NUM_CELLS);

    localparam logic KIND_ROW  = 1'b0;
    localparam logic KIND_DIAG = 1'b1;

    typedef struct packed {
        logic [2:0]        disk_index;
        logic [1:0]        row_index;
        logic [WORD_W-1:0] data_word;
        logic              last_in_stripe;
    } t_in_item;

    typedef struct packed {
        logic              parity_kind;
        logic [1:0]        parity_row;
        logic [WORD_W-1:0] parity_word;
        logic              last_parity;
    } t_out_item;

    typedef struct packed {
        logic hit;    // fold the incoming data word into this cell
        logic shift;  // take the neighbor's word
    } t_cell_ctl;

endpackage

// ===== rtl/evo_cell.sv =====
module evo_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  evo_pkg::t_cell_ctl         i_ctl,
    input  logic [evo_pkg::WORD_W-1:0] i_data,
    input  logic [evo_pkg::WORD_W-1:0] i_shift_in,
    output logic [evo_pkg::WORD_W-1:0] o_word
);
    import evo_pkg::*;

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    // Shift wins; a hit folds the word in.
    always_comb begin
        n_word = r_word;
        if (i_ctl.shift) begin
            n_word = i_shift_in;
        end else if (i_ctl.hit) begin
            n_word = r_word ^ i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ===== rtl/evenodd_parity_encoder.sv =====
// EVENODD encoder: row and diagonal parity over a stripe of DATA_DISKS x (DATA_DISKS-1) words.
// Throughput: one data item per cycle while accumulating; the cell row folds each word in place.
// Drain: after the item marked last, 2*(DATA_DISKS-1) parity items leave one per cycle while i_out_ready
// is high; the drain flag is set first, then the chain's shift through the output register paces it.
// Input is held off during the drain.
// Reset (i_rst_n low, synchronous): all parity cells and the adjuster clear to zero, no output pending.
module evenodd_parity_encoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  evo_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output evo_pkg::t_out_item o_out_item
);
    import evo_pkg::*;

    // Control state
    logic              r_drain;
    logic              n_drain;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out_item         r_out_item;
    t_out_item         n_out_item;
    // Special-diagonal accumulator
    logic [WORD_W-1:0] r_adj;
    logic [WORD_W-1:0] n_adj;

    logic              w_accept;
    logic              w_in_range;
    logic [DIAG_W-1:0] w_row;
    logic [DIAG_W-1:0] w_sum;
    logic [DIAG_W-1:0] w_diag;
    logic              w_load;
    logic              w_is_diag;
    logic [CNT_W-1:0]  w_num;

    t_cell_ctl         w_ctl  [NUM_CELLS];
    logic [WORD_W-1:0] w_word [NUM_CELLS];

    // Take input only outside the parity drain.
    assign o_in_ready = !r_drain;
    assign w_accept   = i_in_valid && o_in_ready;

    // Words off the stripe (bad disk or row) are dropped, but last still counts.
    assign w_row      = DIAG_W'(i_in_item.row_index);
    assign w_in_range = (DIAG_W'(i_in_item.disk_index) < DIAG_W'(DATA_DISKS))
                     && (w_row < DIAG_W'(ROWS));

    // Diagonal (disk + row) mod k: the sum stays below 2k, so one subtract does it.
    assign w_sum  = DIAG_W'(i_in_item.disk_index) + w_row;
    assign w_diag = (w_sum >= DIAG_W'(DATA_DISKS)) ? (w_sum - DIAG_W'(DATA_DISKS)) : w_sum;

    // During the drain, advance the chain whenever the output register is free or being emptied.
    assign w_load = r_drain && (!r_out_valid || i_out_ready);

    // Cells 0..ROWS-1 hold row parity, cells ROWS..2*ROWS-1 diagonal parity.
    // During the drain each cell hands its word toward cell 0, and zeros enter at the far end,
    // so the stores come out cleared after the last shift.
    for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
        logic [WORD_W-1:0] w_shift_in;

        if (j < ROWS) begin : g_row
            assign w_ctl[j].hit = w_accept && w_in_range && (w_row == DIAG_W'(j));
        end else begin : g_diag
            assign w_ctl[j].hit = w_accept && w_in_range && (w_diag == DIAG_W'(j - ROWS));
        end
        assign w_ctl[j].shift = w_load;

        if (j == NUM_CELLS - 1) begin : g_tail
            assign w_shift_in = '0;
        end else begin : g_link
            assign w_shift_in = w_word[j+1];
        end

        evo_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[j]),
            .i_data     (i_in_item.data_word),
            .i_shift_in (w_shift_in),
            .o_word     (w_word[j])
        );
    end

    // Head-of-chain item: row parities first, then diagonals with the adjuster folded in.
    assign w_is_diag = (r_cnt >= CNT_W'(ROWS));
    assign w_num     = w_is_diag ? (r_cnt - CNT_W'(ROWS)) : r_cnt;

    always_comb begin
        n_drain     = r_drain;
        n_cnt       = r_cnt;
        n_adj       = r_adj;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // Hold the special diagonal aside; it adjusts every diagonal on the way out.
        if (w_accept && w_in_range && (w_diag == DIAG_W'(DATA_DISKS - 1))) begin
            n_adj = r_adj ^ i_in_item.data_word;
        end

        if (w_accept && i_in_item.last_in_stripe) begin
            n_drain = 1'b1;
            n_cnt   = '0;
        end

        if (w_load) begin
            n_out_valid             = 1'b1;
            n_out_item.parity_kind  = w_is_diag ? KIND_DIAG : KIND_ROW;
            n_out_item.parity_row   = w_num[1:0];
            n_out_item.parity_word  = w_is_diag ? (w_word[0] ^ r_adj) : w_word[0];
            n_out_item.last_parity  = (r_cnt == CNT_W'(NUM_CELLS - 1));
            if (r_cnt == CNT_W'(NUM_CELLS - 1)) begin
                // Drop out of the drain and clear the adjuster for the next stripe.
                n_drain = 1'b0;
                n_cnt   = '0;
                n_adj   = '0;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain     <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_adj       <= '0;
        end else begin
            r_drain     <= n_drain;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_adj       <= n_adj;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A last item always starts the drain.
    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_item.last_in_stripe) |=> r_drain)
        else $error("drain did not start after last item");

    // The counter rests at zero outside the drain.
    a_cnt_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_drain |-> (r_cnt == '0))
        else $error("drain counter not zero while idle");

    // Leaving the drain coincides with presenting the final parity item.
    a_drain_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_drain)) |-> (r_out_valid && r_out_item.last_parity))
        else $error("drain ended without the final parity item");

    // The final parity item is always a diagonal.
    a_last_is_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.last_parity) |-> (r_out_item.parity_kind == KIND_DIAG))
        else $error("final parity item is not a diagonal");

    // The adjuster is cleared once a stripe has drained.
    a_adj_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_drain)) |-> (r_adj == '0))
        else $error("adjuster not cleared after drain");

endmodule

// ===== tb/evenodd_parity_checker.sv =====
module evenodd_parity_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  evo_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  evo_pkg::t_out_item i_out_item,
    output int                 o_mismatches,
    output int                 o_outstanding,
    output int                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import evo_pkg::*;

    logic [WORD_W-1:0] row_sum  [ROWS];
    logic [WORD_W-1:0] diag_sum [ROWS];
    logic [WORD_W-1:0] adjuster;
    t_out_item         parity_due [$];

    int mismatch_count = 0;
    int checked_count  = 0;

    assign o_mismatches  = mismatch_count;
    assign o_checked     = checked_count;
    assign o_outstanding = parity_due.size();

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic clear_sums();
        for (int i = 0; i < ROWS; i++) begin
            row_sum[i]  = '0;
            diag_sum[i] = '0;
        end
        adjuster = '0;
    endtask

    // Fold one data word into the running sums; on the stripe's last word
    // queue the row parities, then the diagonal parities with the adjuster.
    task automatic fold_word(input t_in_item w);
        int        diag;
        t_out_item p;
        if (w.disk_index < DATA_DISKS && w.row_index < ROWS) begin
            diag = (int'(w.disk_index) + int'(w.row_index)) % DATA_DISKS;
            row_sum[w.row_index] ^= w.data_word;
            if (diag == DATA_DISKS - 1)
                adjuster ^= w.data_word;
            else
                diag_sum[diag] ^= w.data_word;
        end
        if (w.last_in_stripe) begin
            for (int i = 0; i < ROWS; i++) begin
                p.parity_kind = KIND_ROW;
                p.parity_row  = 2'(i);
                p.parity_word = row_sum[i];
                p.last_parity = 1'b0;
                parity_due.insert(parity_due.size(), p);
            end
            for (int i = 0; i < ROWS; i++) begin
                p.parity_kind = KIND_DIAG;
                p.parity_row  = 2'(i);
                p.parity_word = diag_sum[i] ^ adjuster;
                p.last_parity = (i == ROWS - 1);
                parity_due.insert(parity_due.size(), p);
            end
            clear_sums();
        end
    endtask

    task automatic check_parity(input t_out_item got);
        t_out_item want;
        if (parity_due.size() == 0) begin
            report_mismatch($sformatf("parity item with nothing expected: %h", got));
        end else begin
            want = parity_due.pop_front();
            checked_count++;
            if (got.parity_kind !== want.parity_kind)
                report_mismatch($sformatf("parity_kind got %b want %b",
                                          got.parity_kind, want.parity_kind));
            if (got.parity_row !== want.parity_row)
                report_mismatch($sformatf("parity_row got %0d want %0d",
                                          got.parity_row, want.parity_row));
            if (got.parity_word !== want.parity_word)
                report_mismatch($sformatf("parity_word (kind %b row %0d) got %h want %h",
                                          want.parity_kind, want.parity_row,
                                          got.parity_word, want.parity_word));
            if (got.last_parity !== want.last_parity)
                report_mismatch($sformatf("last_parity got %b want %b",
                                          got.last_parity, want.last_parity));
        end
    endtask

    // Results are registered and leave after the item that closes their stripe, so check before folding.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_sums();
            parity_due.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_parity(i_out_item);
            if (i_in_valid && i_in_ready)
                fold_word(i_in_item);
        end
    end

endmodule

// ===== tb/evenodd_parity_encoder_test.sv =====
module evenodd_parity_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import evo_pkg::*;

    localparam int RANDOM_ITEMS = 150;
    localparam int STRIPE_CELLS = DATA_DISKS * ROWS;
    // Worst case per item: a long sender gap plus a full drain of 2*ROWS
    // items, each stalled by the slowest receiver mode; taken many times over.
    localparam int CYCLE_LIMIT  = 400000;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int mismatches;
    int outstanding;
    int checked;

    int items_sent   = 0;
    int stripes_sent = 0;
    int burst_left   = 0;
    int cycle_count  = 0;

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    evenodd_parity_encoder uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    evenodd_parity_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    // Hard stop in case the block hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d parity items still due",
                     cycle_count, outstanding);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver back-pressure: rotate through four stall patterns in turn,
    // so stalls land on every slot of the parity drain.
    always @(negedge clk) begin
        case ((cycle_count / 64) % 4)
            0: out_ready <= 1'b1;                      // never stall
            1: out_ready <= $urandom_range(0, 1);      // coin flip
            2: out_ready <= (cycle_count % 4 == 0);    // sparse, periodic ready
            default: out_ready <= cycle_count[3];      // alternating blocks, from cycle_count[3]
        endcase
    end

    function automatic t_in_item make_word(input int disk, input int row,
                                           input logic [WORD_W-1:0] data,
                                           input logic last);
        t_in_item w;
        w.disk_index     = 3'(disk);
        w.row_index      = 2'(row);
        w.data_word      = data;
        w.last_in_stripe = last;
        return w;
    endfunction

    // Lean toward extremes and single-bit patterns now and then.
    function automatic logic [WORD_W-1:0] rand_data();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, WORD_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Call at a falling edge. Hold the item until accepted, then either keep
    // valid up for the next item of the burst or drop it for a random gap.
    task automatic push_word(input t_in_item w);
        in_valid <= 1'b1;
        in_item  <= w;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (w.last_in_stripe)
            stripes_sent++;
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 6);
        end
    endtask

    initial begin
        int order [STRIPE_CELLS];
        int random_done;
        int n;
        int j;
        int tmp;
        int disk;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: lone words, the special diagonal, ignored disks, extremes.
        push_word(make_word(0, 0, '1, 1'b1));
        push_word(make_word(4, 0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1));  // adjuster only
        push_word(make_word(7, 3, '1, 1'b1));                       // ignored, still closes
        push_word(make_word(5, 2, rand_data(), 1'b0));
        push_word(make_word(6, 1, rand_data(), 1'b0));
        push_word(make_word(3, 3, 64'h5555_5555_5555_5555, 1'b1));
        // Whole special diagonal: every diagonal parity equals the adjuster.
        push_word(make_word(1, 3, 64'h0123_4567_89AB_CDEF, 1'b0));
        push_word(make_word(2, 2, 64'hFEDC_BA98_7654_3210, 1'b0));
        push_word(make_word(3, 1, '1, 1'b0));
        push_word(make_word(4, 0, 64'h8000_0000_0000_0001, 1'b1));
        // One word per disk on the top row, folding against each other.
        for (int d = 0; d < DATA_DISKS; d++)
            push_word(make_word(d, ROWS - 1, rand_data(), d == DATA_DISKS - 1));
        push_word(make_word(2, 1, '0, 1'b1));

        // Random: mostly complete stripes in shuffled order, some partial or
        // repeated ones, and stray words on disks that do not exist.
        random_done = 0;
        while (random_done < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    for (int i = 0; i < STRIPE_CELLS; i++)
                        order[i] = i;
                    for (int i = STRIPE_CELLS - 1; i > 0; i--) begin
                        j = $urandom_range(0, i);
                        tmp = order[i];
                        order[i] = order[j];
                        order[j] = tmp;
                    end
                    for (int i = 0; i < STRIPE_CELLS; i++)
                        push_word(make_word(order[i] % DATA_DISKS, order[i] / DATA_DISKS,
                                            rand_data(), i == STRIPE_CELLS - 1));
                    random_done += STRIPE_CELLS;
                end
                6, 7: begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++) begin
                        disk = ($urandom_range(0, 9) < 8) ? $urandom_range(0, DATA_DISKS - 1)
                                                          : $urandom_range(DATA_DISKS, 7);
                        push_word(make_word(disk, $urandom_range(0, 3), rand_data(),
                                            i == n - 1));
                        if (disk < DATA_DISKS)
                            random_done++;
                    end
                end
                8: begin
                    push_word(make_word($urandom_range(DATA_DISKS, 7), $urandom_range(0, 3),
                                        rand_data(), $urandom_range(0, 1)));
                end
                default: begin
                    n = $urandom_range(8, 24);
                    for (int i = 0; i < n; i++)
                        push_word(make_word($urandom_range(0, DATA_DISKS - 1),
                                            $urandom_range(0, ROWS - 1),
                                            rand_data(), i == n - 1));
                    random_done += n;
                end
            endcase
        end
        // Close any stripe left open so its parity is drained and checked.
        push_word(make_word($urandom_range(0, DATA_DISKS - 1), $urandom_range(0, ROWS - 1),
                            rand_data(), 1'b1));
        in_valid <= 1'b0;

        // Drain, then watch a little longer for stray parity items.
        while (outstanding != 0)
            @(negedge clk);
        repeat (2 * NUM_CELLS + 8) @(negedge clk);

        $display("Sent %0d data items closing %0d stripes, checked %0d parity items",
                 items_sent, stripes_sent, checked);
        $display("Mismatches: %0d, parity items never seen: %0d", mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
